// File: design/msod_pkg.sv
// Shared types, constants and table functions for the ModR/M operand decoder.
package msod_pkg;

    // Widths of the stream words
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 64;

    // Register indexes of the configuration port
    localparam logic CFG_OPERAND_32 = 1'b0;
    localparam logic CFG_ADDRESS_32 = 1'b1;

    // Register code that means no base or no index register
    localparam logic [3:0] REG_NONE = 4'd8;

    // Size classes
    localparam logic [3:0] SZ_B = 4'd0;
    localparam logic [3:0] SZ_W = 4'd1;
    localparam logic [3:0] SZ_D = 4'd2;
    localparam logic [3:0] SZ_Q = 4'd3;
    localparam logic [3:0] SZ_S = 4'd4;
    localparam logic [3:0] SZ_L = 4'd5;
    localparam logic [3:0] SZ_T = 4'd6;
    localparam logic [3:0] SZ_C = 4'd7;
    localparam logic [3:0] SZ_V = 4'd8;
    localparam logic [3:0] SZ_P = 4'd9;

    // ModR/M mod field codes
    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISPW  = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;

    // Special rm and SIB field codes
    localparam logic [2:0] RM_SIB    = 3'd4;
    localparam logic [2:0] RM_DIR32  = 3'd5;
    localparam logic [2:0] RM_DIR16  = 3'd6;
    localparam logic [2:0] SIB_NOIDX = 3'd4;
    localparam logic [2:0] SIB_NOBAS = 3'd5;

    typedef enum logic [1:0] {
        KIND_GPR     = 2'd0,
        KIND_MMX     = 2'd1,
        KIND_MEMORY  = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    // One input word, unpacked
    typedef struct packed {
        logic        address_override;
        logic        operand_override;
        logic        mmx_form;
        logic        allow_memory;
        logic        allow_register;
        logic [3:0]  size_class;
        logic [3:0]  bytes_left;
        logic [39:0] following_bytes;
        logic [7:0]  modrm_byte;
    } in_item_t;

    // One result word, unpacked
    typedef struct packed {
        logic               address_32;
        logic [2:0]         bytes_consumed;
        logic signed [31:0] displacement;
        logic               has_displacement;
        logic [3:0]         scale_factor;
        logic [3:0]         index_register;
        logic [3:0]         base_register;
        logic               float_pointer;
        logic [3:0]         operand_bytes;
        logic [2:0]         register_number;
        kind_t              operand_kind;
    } res_t;

    // Operand size in bytes for a size class and the effective operand size.
    function automatic logic [3:0] size_bytes(input logic [3:0] sclass, input logic op32);
        logic [3:0] n;
        begin
            unique case (sclass)
                SZ_B:    n = 4'd1;
                SZ_W:    n = 4'd2;
                SZ_D:    n = 4'd4;
                SZ_Q:    n = 4'd8;
                SZ_S:    n = 4'd4;
                SZ_L:    n = 4'd8;
                SZ_T:    n = 4'd10;
                SZ_C:    n = op32 ? 4'd2 : 4'd1;
                SZ_V:    n = op32 ? 4'd4 : 4'd2;
                SZ_P:    n = op32 ? 4'd6 : 4'd4;
                default: n = 4'd0;
            endcase
            return n;
        end
    endfunction

    // Base register of the 16-bit addressing forms.
    function automatic logic [3:0] base16(input logic [2:0] rm);
        logic [3:0] r;
        begin
            unique case (rm)
                3'd0, 3'd1, 3'd7: r = 4'd3;
                3'd2, 3'd3, 3'd6: r = 4'd5;
                3'd4:             r = 4'd6;
                3'd5:             r = 4'd7;
                default:          r = REG_NONE;
            endcase
            return r;
        end
    endfunction

    // Index register of the 16-bit addressing forms.
    function automatic logic [3:0] index16(input logic [2:0] rm);
        logic [3:0] r;
        begin
            unique case (rm)
                3'd0, 3'd2: r = 4'd6;
                3'd1, 3'd3: r = 4'd7;
                default:    r = REG_NONE;
            endcase
            return r;
        end
    endfunction

endpackage

// File: design/msod_decode.sv
// Combinational decode of one ModR/M operand from the input register.
module msod_decode (
    input  msod_pkg::in_item_t item,
    input  logic               dflt_op32,
    input  logic               dflt_ad32,
    output msod_pkg::res_t     res
);
    import msod_pkg::*;

    logic        op32;
    logic        ad32;
    logic [1:0]  md;
    logic [2:0]  rm;
    logic [7:0]  sib;
    logic        bad;
    logic        pos;
    logic [2:0]  dlen;
    logic        sext;
    logic [2:0]  used;
    logic [31:0] win;
    logic [31:0] disp;

    assign op32 = dflt_op32 ^ item.operand_override;
    assign ad32 = dflt_ad32 ^ item.address_override;
    assign md   = item.modrm_byte[7:6];
    assign rm   = item.modrm_byte[2:0];
    assign sib  = item.following_bytes[7:0];

    // Displacement bytes start after the SIB byte when there is one.
    assign win = pos ? item.following_bytes[39:8] : item.following_bytes[31:0];

    // Displacement extension by length.
    always_comb
    begin
        unique case (dlen)
            3'd1:    disp = {{24{win[7]}}, win[7:0]};
            3'd2:    disp = sext ? {{16{win[15]}}, win[15:0]} : {16'd0, win[15:0]};
            3'd4:    disp = win;
            default: disp = 32'd0;
        endcase
    end

    // Form selection and addressing rules.
    always_comb
    begin
        res                  = '0;
        res.operand_kind     = KIND_INVALID;
        res.base_register    = REG_NONE;
        res.index_register   = REG_NONE;
        res.bytes_consumed   = 3'd1;
        res.address_32       = ad32;
        bad                  = (item.bytes_left == 4'd0);
        pos                  = 1'b0;
        dlen                 = 3'd0;
        sext                 = 1'b1;
        used                 = 3'd1;

        if (md == MOD_REG)
        begin
            if (!item.allow_register)
            begin
                bad = 1'b1;
            end
            else
            begin
                res.operand_kind    = item.mmx_form ? KIND_MMX : KIND_GPR;
                res.register_number = rm;
                res.operand_bytes   = item.mmx_form ? 4'd8 : size_bytes(item.size_class, op32);
            end
        end
        else if (!item.allow_memory)
        begin
            bad = 1'b1;
        end
        else
        begin
            res.operand_kind  = KIND_MEMORY;
            res.operand_bytes = size_bytes(item.size_class, op32);
            res.float_pointer = (item.size_class == SZ_S) || (item.size_class == SZ_L)
                                || (item.size_class == SZ_T);
            priority if (!ad32)
            begin
                // 16-bit addressing table
                if (md == MOD_NODISP && rm == RM_DIR16)
                begin
                    dlen = 3'd2;
                    sext = 1'b0;
                end
                else
                begin
                    res.base_register  = base16(rm);
                    res.index_register = index16(rm);
                    res.scale_factor   = 4'd1;
                    dlen = (md == MOD_DISP8) ? 3'd1 : (md == MOD_DISPW) ? 3'd2 : 3'd0;
                end
            end
            else if (md == MOD_NODISP && rm == RM_DIR32)
            begin
                dlen = 3'd4;
            end
            else if (rm == RM_SIB)
            begin
                // 32-bit form with a SIB byte
                pos                = 1'b1;
                res.index_register = (sib[5:3] == SIB_NOIDX) ? REG_NONE : {1'b0, sib[5:3]};
                res.scale_factor   = 4'(4'd1 << sib[7:6]);
                if (sib[2:0] == SIB_NOBAS && md == MOD_NODISP)
                begin
                    dlen = 3'd4;
                end
                else
                begin
                    res.base_register = {1'b0, sib[2:0]};
                    dlen = (md == MOD_DISP8) ? 3'd1 : (md == MOD_DISPW) ? 3'd4 : 3'd0;
                end
            end
            else
            begin
                res.base_register = {1'b0, rm};
                res.scale_factor  = 4'd1;
                dlen = (md == MOD_DISP8) ? 3'd1 : (md == MOD_DISPW) ? 3'd4 : 3'd0;
            end

            used = 3'd1 + {2'b00, pos} + dlen;
            if ({1'b0, used} > item.bytes_left)
            begin
                bad = 1'b1;
            end
            res.has_displacement = (dlen != 3'd0);
            res.displacement     = disp;
            res.bytes_consumed   = used;
        end

        // A disallowed or truncated operand gives the invalid result.
        if (bad)
        begin
            res                = '0;
            res.operand_kind   = KIND_INVALID;
            res.base_register  = REG_NONE;
            res.index_register = REG_NONE;
            res.bytes_consumed = 3'd1;
            res.address_32     = ad32;
        end
    end

endmodule

// File: design/msod_out_stage.sv
// Result register with its valid flag, driving the master-side stream.
module msod_out_stage (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  msod_pkg::res_t                       res,
    output logic                                 advance,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: operand_kind, register_number, operand_bytes,
    // float_pointer, base_register, index_register, scale_factor,
    // has_displacement, displacement, bytes_consumed, address_32, zero fill.
    output logic [msod_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import msod_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // The register takes a new word when empty or when its word leaves.
    assign advance    = !valid_reg || m_tready;
    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, res_reg};

endmodule

// File: design/modrm_sib_operand_decoder.sv
// Top level of the ModR/M and SIB operand decoder: configuration, input register, decode, result register.
//
// Decodes one x86 ModR/M operand (with optional SIB byte and displacement) per
// input word into its kind, register, size, base, index, scale, displacement and
// byte count. A word passes an input register and a result register. Each result
// is offered on the output by the result register once its word has moved on
// from the input register. A new word can be accepted in every cycle while the
// output side keeps taking results, because the input register hands its word
// on in the same cycle that the result register empties. When the output stalls,
// the block holds two words and then drops s_tready until a result is taken. The
// default operand and address sizes are written through the configuration port
// (index 0 and 1) and both reset to 32-bit; write them only while no word is in
// flight.
module modrm_sib_operand_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic                                cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: modrm_byte, following_bytes, bytes_left, size_class,
    // allow_register, allow_memory, mmx_form, operand_override,
    // address_override, zero fill.
    input  logic [msod_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: operand_kind, register_number, operand_bytes,
    // float_pointer, base_register, index_register, scale_factor,
    // has_displacement, displacement, bytes_consumed, address_32, zero fill.
    output logic [msod_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import msod_pkg::*;

    logic     op32_reg;
    logic     ad32_reg;
    logic     in_valid_reg;
    logic     in_valid_next;
    in_item_t item_reg;
    res_t     res;
    logic     advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op32_reg <= 1'b1;
            ad32_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OPERAND_32: op32_reg <= cfg_wdata;
                CFG_ADDRESS_32: ad32_reg <= cfg_wdata;
                default:        op32_reg <= op32_reg;
            endcase
        end
    end

    // Input register: free or moving on into the result register.
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
        end
    end

    // Operand decode.
    msod_decode u_decode (
        .item      (item_reg),
        .dflt_op32 (op32_reg),
        .dflt_ad32 (ad32_reg),
        .res       (res)
    );

    // Result register and output stream.
    msod_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .res      (res),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
